>>> rtl/core/gshare_branch_predictor_macros.svh
// ------------------------------------------------------------------------
// gshare branch predictor assertion macros
// shared concurrent assertion forms for the predictor rtl
// ------------------------------------------------------------------------
`ifndef GSHARE_BRANCH_PREDICTOR_MACROS_SVH
`define GSHARE_BRANCH_PREDICTOR_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define GBP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define GBP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

>>> rtl/core/gbp_pkg.sv
// ------------------------------------------------------------------------
// gshare predictor package
// shared constants and codes for the gshare branch predictor
// ------------------------------------------------------------------------
package gbp_pkg;

    localparam int MAX_HISTORY_BITS_DEF = 13;
    localparam int QUEUE_DEPTH          = 2;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 4;
    localparam int HIST_CFG_W  = 4;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_MODE         = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HISTORY_BITS = 1'd1;

    // register reset values
    localparam logic                  MODE_RESET         = 1'b1;
    localparam logic [HIST_CFG_W-1:0] HISTORY_BITS_RESET = 4'd13;

    // mode codes
    localparam logic MODE_STATIC = 1'b0;
    localparam logic MODE_GSHARE = 1'b1;

    // operation codes
    localparam logic OP_PREDICT = 1'b0;
    localparam logic OP_TRAIN   = 1'b1;

    // counter values
    localparam logic [1:0] CTR_RESET = 2'd1;
    localparam logic [1:0] CTR_MIN   = 2'd0;
    localparam logic [1:0] CTR_MAX   = 2'd3;

endpackage

>>> rtl/core/gbp_front.sv
// ------------------------------------------------------------------------
// gshare predictor front end
// owns the global history, forms the table index and queue entry
// ------------------------------------------------------------------------
module gbp_front #(
    parameter int MAX_HISTORY_BITS = gbp_pkg::MAX_HISTORY_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   accept,
    input  logic                                   operation,
    input  logic [31:0]                            branch_address,
    input  logic                                   outcome,
    input  logic [gbp_pkg::HIST_CFG_W-1:0]         history_bits,
    output logic                                   push,
    output logic [MAX_HISTORY_BITS+1:0]            entry
);

    localparam int AW = MAX_HISTORY_BITS;

    logic [AW-1:0] history_reg;
    logic [AW-1:0] history_next;
    logic [AW-1:0] mask;
    logic [AW-1:0] idx;

    // index mask from the configured length, wider settings saturate at AW
    always_comb
    begin
        for (int i = 0; i < AW; i++)
        begin
            mask[i] = (int'(history_bits) > i);
        end
    end

    assign idx = (branch_address[AW-1:0] ^ history_reg) & mask;

    always_comb
    begin
        history_next = history_reg;
        if (accept && (operation == gbp_pkg::OP_TRAIN))
        begin
            history_next = AW'({history_reg, outcome}) & mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            history_reg <= '0;
        end
        else
        begin
            history_reg <= history_next;
        end
    end

    assign push  = accept;
    assign entry = {operation, outcome, idx};

endmodule

>>> rtl/core/gbp_queue.sv
// ------------------------------------------------------------------------
// gshare predictor queue
// small fifo between front end and table back end
// ------------------------------------------------------------------------
module gbp_queue #(
    parameter int WIDTH = 15,
    parameter int DEPTH = gbp_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = slots[rd_ptr_reg];

endmodule

>>> rtl/core/gbp_back.sv
// ------------------------------------------------------------------------
// gshare predictor back end
// counter table, clearing sweep and read-modify-write sequencer
// ------------------------------------------------------------------------
`include "gshare_branch_predictor_macros.svh"

module gbp_back #(
    parameter int MAX_HISTORY_BITS = gbp_pkg::MAX_HISTORY_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        mode,
    input  logic                        q_empty,
    input  logic [MAX_HISTORY_BITS+1:0] q_data,
    output logic                        pop,
    output logic                        clearing,
    output logic                        done,
    output logic                        prediction
);

    localparam int AW    = MAX_HISTORY_BITS;
    localparam int DEPTH = 1 << AW;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_WAIT  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [1:0]    table_mem [DEPTH];
    logic [1:0]    rd_data_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic [AW-1:0] clr_cnt_next;
    logic [AW-1:0] idx_reg;
    logic          op_reg;
    logic          outcome_reg;
    logic          done_reg;
    logic          done_next;
    logic          prediction_reg;
    logic          prediction_next;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [1:0]    mem_wdata;
    logic [1:0]    ctr_upd;

    assign pop      = (state_reg == S_IDLE) && !q_empty;
    assign clearing = (state_reg == S_CLEAR);

    // saturating step toward the resolved direction
    always_comb
    begin
        if (outcome_reg)
        begin
            ctr_upd = (rd_data_reg == gbp_pkg::CTR_MAX) ? rd_data_reg : rd_data_reg + 2'd1;
        end
        else
        begin
            ctr_upd = (rd_data_reg == gbp_pkg::CTR_MIN) ? rd_data_reg : rd_data_reg - 2'd1;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg;
        mem_wdata       = ctr_upd;
        done_next       = 1'b0;
        prediction_next = prediction_reg;
        case (state_reg)
            S_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = gbp_pkg::CTR_RESET;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (&clr_cnt_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                state_next = S_IDLE;
                if (op_reg == gbp_pkg::OP_TRAIN)
                begin
                    mem_we = 1'b1;
                end
                else
                begin
                    done_next       = 1'b1;
                    prediction_next = (mode == gbp_pkg::MODE_STATIC) ? 1'b1 : rd_data_reg[1];
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            done_reg    <= done_next;
        end
    end

    // item latch and result payload
    always_ff @(posedge clk)
    begin
        prediction_reg <= prediction_next;
        if (pop)
        begin
            op_reg      <= q_data[AW+1];
            outcome_reg <= q_data[AW];
            idx_reg     <= q_data[AW-1:0];
        end
    end

    // counter table, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= table_mem[q_data[AW-1:0]];
    end

    assign done       = done_reg;
    assign prediction = prediction_reg;

    `GBP_ASSERT_NEXT(a_done_only_after_wait, clk, rst_n, state_reg != S_WAIT, !done_reg)
    `GBP_ASSERT_IMP(a_no_pop_in_clear, clk, rst_n, state_reg == S_CLEAR, !pop)
    `GBP_ASSERT_IMP(a_queue_empty_in_clear, clk, rst_n, state_reg == S_CLEAR, q_empty)
    `GBP_ASSERT_NEXT(a_pop_then_wait, clk, rst_n, pop, state_reg == S_WAIT)

endmodule

>>> rtl/core/gshare_branch_predictor.sv
// ------------------------------------------------------------------------
// gshare branch predictor
// direction predictor with 2-bit counters indexed by pc xor history
// ------------------------------------------------------------------------
// usage:
//   command channel: a transaction is taken at a clock edge with start high
//   and busy low; operation selects predict or train, outcome is used only
//   by train
//   result channel: done is high for one cycle with prediction valid; only
//   predict transactions return a result, train returns nothing
//   config port: cfg_we writes cfg_data into register cfg_index (0 mode,
//   1 history_bits) at the clock edge; the user must write only while no
//   transaction is in flight, as the block itself does not enforce it
//   a prediction passes the queue, item latch and registered table read
//   before done rises, once the table sequencer is free; the back end
//   starts no new transaction until its read-then-write sequence ends, and
//   a two-entry queue lets the front take transactions while it works
//   reset: history clears, registers return to mode 1 and 13 history bits,
//   then busy stays high while all 2^MAX_HISTORY_BITS (8192 by default)
//   counter table entries are swept to weakly not taken
//   the receiver cannot stall; results are never held back
// ------------------------------------------------------------------------
module gshare_branch_predictor #(
    parameter int MAX_HISTORY_BITS = gbp_pkg::MAX_HISTORY_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // command channel
    input  logic                           start,
    output logic                           busy,
    input  logic                           operation,
    input  logic [31:0]                    branch_address,
    input  logic                           outcome,
    // result channel
    output logic                           done,
    output logic                           prediction,
    // configuration write port
    input  logic                           cfg_we,
    input  logic [gbp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [gbp_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int ENTRY_W = MAX_HISTORY_BITS + 2;

    // configuration registers
    logic                          mode_reg;
    logic                          mode_next;
    logic [gbp_pkg::HIST_CFG_W-1:0] history_bits_reg;
    logic [gbp_pkg::HIST_CFG_W-1:0] history_bits_next;

    // front to queue to back
    logic               accept;
    logic               push;
    logic [ENTRY_W-1:0] push_entry;
    logic               pop;
    logic [ENTRY_W-1:0] pop_entry;
    logic               q_full;
    logic               q_empty;
    logic               clearing;

    always_comb
    begin
        mode_next         = mode_reg;
        history_bits_next = history_bits_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                gbp_pkg::REG_MODE:
                begin
                    mode_next = cfg_data[0];
                end
                gbp_pkg::REG_HISTORY_BITS:
                begin
                    history_bits_next = cfg_data[gbp_pkg::HIST_CFG_W-1:0];
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= gbp_pkg::MODE_RESET;
            history_bits_reg <= gbp_pkg::HISTORY_BITS_RESET;
        end
        else
        begin
            mode_reg         <= mode_next;
            history_bits_reg <= history_bits_next;
        end
    end

    // hold off commands during the table sweep or when the queue is full
    assign busy   = clearing || q_full;
    assign accept = start && !busy;

    // front: history and index forming
    gbp_front #(
        .MAX_HISTORY_BITS (MAX_HISTORY_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .operation      (operation),
        .branch_address (branch_address),
        .outcome        (outcome),
        .history_bits   (history_bits_reg),
        .push           (push),
        .entry          (push_entry)
    );

    // decoupling queue
    gbp_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (gbp_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_entry),
        .pop       (pop),
        .pop_data  (pop_entry),
        .full      (q_full),
        .empty     (q_empty)
    );

    // back: counter table read-modify-write
    gbp_back #(
        .MAX_HISTORY_BITS (MAX_HISTORY_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode       (mode_reg),
        .q_empty    (q_empty),
        .q_data     (pop_entry),
        .pop        (pop),
        .clearing   (clearing),
        .done       (done),
        .prediction (prediction)
    );

endmodule
